[sv/vcs_pkg.sv]
// ---------------------------------------------------------------------------
// vcs_pkg
// Shared types and constants of the streaming valid 2D convolution block.
// ---------------------------------------------------------------------------
package vcs_pkg;

  localparam int CONV_W     = 38;
  localparam int ROW_W      = 10;
  localparam int COEF_W     = 16;
  localparam int IDX_W      = 6;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int KSZ_W      = 3;
  localparam int MAX_HEIGHT = 1024;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             last;
  } meta_t;

endpackage

[sv/valid_conv2d_stream_top.sv]
// ---------------------------------------------------------------------------
// valid_conv2d_stream_top
// Streaming valid 2D convolution over a raster pixel stream.
// ---------------------------------------------------------------------------
// Input beats either load one kernel coefficient (operation 0) or carry one
// raster pixel (operation 1). Every pixel at row and column of at least
// the kernel side minus one yields one output beat with the full-precision
// window sum, its output coordinates and a last-of-frame flag; coefficient
// beats and border pixels yield nothing.
// Throughput: one beat per cycle unless in_stall_o is raised. Each pixel
// reads all stored lines at once, one memory per line, read at the current column.
// Each output beat is registered through the line read, window shift,
// products, row sums and final sum after the edge that accepts its pixel.
// Reset clears counters, window and coefficients; the line memories are not
// cleared, so no clearing pass is needed. Register writes restart the frame.
// When the receiver stalls, the pipeline fills its empty stages and then
// raises in_stall_o; nothing is dropped.
// ---------------------------------------------------------------------------
module valid_conv2d_stream_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 7,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [vcs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [vcs_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic [vcs_pkg::IDX_W-1:0]            coef_index_i,
  input  logic signed [vcs_pkg::COEF_W-1:0]    coef_value_i,
  input  logic signed [PIXEL_BITS-1:0]         pixel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [vcs_pkg::CONV_W-1:0]    conv_sum_o,
  output logic [vcs_pkg::ROW_W-1:0]            out_row_o,
  output logic [vcs_pkg::ROW_W-1:0]            out_col_o,
  output logic                                 frame_last_o
);

  localparam int LINES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int SLW   = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int K_RST = (MAX_KERNEL < 3) ? MAX_KERNEL : 3;

  logic [vcs_pkg::CFG_W-1:0]   width_q, height_q;
  logic [vcs_pkg::KSZ_W-1:0]   ksz_q;
  logic [CW-1:0]               col_q;
  logic [vcs_pkg::ROW_W-1:0]   row_q;
  logic [SLW-1:0]              slot_q;

  logic                              p1v_q, p1op_q, p1emit_q;
  logic [vcs_pkg::IDX_W-1:0]         p1idx_q;
  logic signed [vcs_pkg::COEF_W-1:0] p1coef_q;
  logic signed [PIXEL_BITS-1:0]      p1px_q;
  logic [SLW-1:0]                    p1slot_q;
  vcs_pkg::meta_t                    p1meta_q, meta_d, meta_out;

  logic signed [PIXEL_BITS-1:0] rd [LINES];
  logic take, free1, in_acc, pix_acc, cfg_hit, col_end, row_end, emit_d;
  logic [vcs_pkg::KSZ_W-1:0] kv;

  assign free1      = !p1v_q || take;
  assign in_stall_o = !free1;
  assign in_acc     = in_valid_i && free1;
  assign pix_acc    = in_acc && operation_i == vcs_pkg::OP_PIXEL;
  assign cfg_hit    = cfg_we_i && (cfg_index_i == vcs_pkg::REG_WIDTH ||
                      cfg_index_i == vcs_pkg::REG_HEIGHT || cfg_index_i == vcs_pkg::REG_KERNEL);
  assign col_end    = 32'(col_q) + 32'd1 >= 32'(width_q);
  assign row_end    = 32'(row_q) + 32'd1 >= 32'(height_q);
  assign emit_d     = 32'(row_q) + 32'd1 >= 32'(ksz_q) && 32'(col_q) + 32'd1 >= 32'(ksz_q);
  assign kv         = cfg_data_i[vcs_pkg::KSZ_W-1:0];

  always_comb begin
    meta_d.row  = vcs_pkg::ROW_W'(32'(row_q) - 32'(ksz_q) + 32'd1);
    meta_d.col  = vcs_pkg::ROW_W'(32'(col_q) - 32'(ksz_q) + 32'd1);
    meta_d.last = col_end && row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= vcs_pkg::CFG_W'(W_RST);
      height_q <= vcs_pkg::CFG_W'(vcs_pkg::MAX_HEIGHT);
      ksz_q    <= vcs_pkg::KSZ_W'(K_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vcs_pkg::REG_WIDTH: begin
          if (cfg_data_i == '0) width_q <= vcs_pkg::CFG_W'(1);
          else if (32'(cfg_data_i) > MAX_WIDTH) width_q <= vcs_pkg::CFG_W'(MAX_WIDTH);
          else width_q <= cfg_data_i;
        end
        vcs_pkg::REG_HEIGHT: begin
          if (cfg_data_i == '0) height_q <= vcs_pkg::CFG_W'(1);
          else if (32'(cfg_data_i) > vcs_pkg::MAX_HEIGHT)
            height_q <= vcs_pkg::CFG_W'(vcs_pkg::MAX_HEIGHT);
          else height_q <= cfg_data_i;
        end
        vcs_pkg::REG_KERNEL: begin
          if (kv == '0) ksz_q <= vcs_pkg::KSZ_W'(1);
          else if (32'(kv) > MAX_KERNEL) ksz_q <= vcs_pkg::KSZ_W'(MAX_KERNEL);
          else ksz_q <= kv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (cfg_hit) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (pix_acc) begin
      if (col_end) begin
        col_q <= '0;
        if (row_end) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + 1'b1;
          slot_q <= (32'(slot_q) == LINES - 1) ? '0 : slot_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1v_q <= 1'b0;
    end else if (free1) begin
      p1v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1op_q   <= operation_i;
      p1idx_q  <= coef_index_i;
      p1coef_q <= coef_value_i;
      p1px_q   <= pixel_i;
      p1slot_q <= slot_q;
      p1emit_q <= emit_d;
      p1meta_q <= meta_d;
    end
  end

  for (genvar g = 0; g < LINES; g++) begin : g_line
    vcs_line_mem #(
      .DEPTH(MAX_WIDTH),
      .W    (PIXEL_BITS)
    ) u_mem (
      .clk_i  (clk_i),
      .re_i   (pix_acc),
      .we_i   (pix_acc && slot_q == SLW'(g)),
      .addr_i (col_q),
      .wdata_i(pixel_i),
      .rdata_o(rd[g])
    );
  end

  vcs_core #(
    .MK   (MAX_KERNEL),
    .PB   (PIXEL_BITS),
    .LINES(LINES),
    .SLW  (SLW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ksize_i      (ksz_q),
    .s1_valid_i   (p1v_q),
    .s1_op_i      (p1op_q),
    .s1_idx_i     (p1idx_q),
    .s1_coef_i    (p1coef_q),
    .s1_px_i      (p1px_q),
    .s1_slot_i    (p1slot_q),
    .s1_emit_i    (p1emit_q),
    .s1_meta_i    (p1meta_q),
    .rd_i         (rd),
    .s1_take_o    (take),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .conv_sum_o   (conv_sum_o),
    .meta_o       (meta_out)
  );

  assign out_row_o    = meta_out.row;
  assign out_col_o    = meta_out.col;
  assign frame_last_o = meta_out.last;

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> col_q == '0 && row_q == '0 && slot_q == '0)
    else $error("register write did not restart the frame");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < LINES)
    else $error("line slot out of range");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(width_q))
    else $error("column counter beyond image width");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !p1v_q |-> !in_stall_o)
    else $error("input stalled with empty first stage");

endmodule

[sv/vcs_line_mem.sv]
// ---------------------------------------------------------------------------
// vcs_line_mem
// One line of pixel storage: synchronous memory, read-first, registered read.
// ---------------------------------------------------------------------------
module vcs_line_mem #(
  parameter int DEPTH = 1024,
  parameter int W     = 16
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic signed [W-1:0]      wdata_i,
  output logic signed [W-1:0]      rdata_o
);

  logic signed [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

endmodule

[sv/vcs_core.sv]
// ---------------------------------------------------------------------------
// vcs_core
// Window and coefficient registers, product lanes and registered adder tree.
// ---------------------------------------------------------------------------
module vcs_core #(
  parameter int MK    = 7,
  parameter int PB    = 16,
  parameter int LINES = 6,
  parameter int SLW   = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [vcs_pkg::KSZ_W-1:0]         ksize_i,
  input  logic                              s1_valid_i,
  input  logic                              s1_op_i,
  input  logic [vcs_pkg::IDX_W-1:0]         s1_idx_i,
  input  logic signed [vcs_pkg::COEF_W-1:0] s1_coef_i,
  input  logic signed [PB-1:0]              s1_px_i,
  input  logic [SLW-1:0]                    s1_slot_i,
  input  logic                              s1_emit_i,
  input  vcs_pkg::meta_t                    s1_meta_i,
  input  logic signed [PB-1:0]              rd_i [LINES],
  output logic                              s1_take_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [vcs_pkg::CONV_W-1:0] conv_sum_o,
  output vcs_pkg::meta_t                    meta_o
);

  localparam int NC   = MK * MK;
  localparam int CIW  = (NC > 1) ? $clog2(NC) : 1;
  localparam int PW   = PB + vcs_pkg::COEF_W;
  localparam int SUMW = PW + 8;

  logic signed [PB-1:0]              window_q [MK][MK];
  logic signed [vcs_pkg::COEF_W-1:0] coef_q [NC];
  logic signed [PB-1:0]              col_d [MK];
  logic signed [PW-1:0]              prod_d [MK][MK];
  logic signed [PW-1:0]              prod_q [MK][MK];
  logic signed [SUMW-1:0]            rsum_d [MK];
  logic signed [SUMW-1:0]            rsum_q [MK];
  logic signed [SUMW-1:0]            total_d;

  logic p2v_q, p3v_q, p4v_q, ov_q;
  vcs_pkg::meta_t meta2_q, meta3_q, meta4_q, meta_out_q;
  logic signed [vcs_pkg::CONV_W-1:0] sum_out_q;
  logic ov_free, f4, f3, f2, mv1;

  assign ov_free   = !ov_q || !out_stall_i;
  assign f4        = !p4v_q || ov_free;
  assign f3        = !p3v_q || f4;
  assign f2        = !p2v_q || f3;
  assign s1_take_o = f2;
  assign mv1       = s1_valid_i && f2;

  always_comb begin
    int t;
    col_d[0] = s1_px_i;
    for (int d = 1; d < MK; d++) begin
      t = int'(s1_slot_i) + LINES - d;
      if (t >= LINES) t = t - LINES;
      if (d < int'(ksize_i)) col_d[d] = rd_i[SLW'(t)];
      else col_d[d] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < MK; d++)
        for (int m = 0; m < MK; m++) window_q[d][m] <= '0;
    end else if (mv1 && s1_op_i == vcs_pkg::OP_PIXEL) begin
      for (int d = 0; d < MK; d++) begin
        for (int m = MK - 1; m > 0; m--) window_q[d][m] <= window_q[d][m-1];
        window_q[d][0] <= col_d[d];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NC; i++) coef_q[i] <= '0;
    end else if (mv1 && s1_op_i == vcs_pkg::OP_COEF && int'(s1_idx_i) < NC) begin
      coef_q[CIW'(s1_idx_i)] <= s1_coef_i;
    end
  end

  always_comb begin
    int k;
    int ci;
    k = int'(ksize_i);
    for (int a = 0; a < MK; a++) begin
      for (int b = 0; b < MK; b++) begin
        ci = (k - 1 - a) * k + (k - 1 - b);
        if (a < k && b < k) prod_d[a][b] = window_q[a][b] * coef_q[CIW'(ci)];
        else prod_d[a][b] = '0;
      end
    end
  end

  always_comb begin
    for (int a = 0; a < MK; a++) begin
      rsum_d[a] = '0;
      for (int b = 0; b < MK; b++) rsum_d[a] = rsum_d[a] + SUMW'(prod_q[a][b]);
    end
    total_d = '0;
    for (int a = 0; a < MK; a++) total_d = total_d + rsum_q[a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2v_q <= 1'b0;
      p3v_q <= 1'b0;
      p4v_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (f2) p2v_q <= s1_valid_i && s1_op_i == vcs_pkg::OP_PIXEL && s1_emit_i;
      if (f3) p3v_q <= p2v_q;
      if (f4) p4v_q <= p3v_q;
      if (ov_free) ov_q <= p4v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f2) meta2_q <= s1_meta_i;
    if (f3) begin
      meta3_q <= meta2_q;
      prod_q  <= prod_d;
    end
    if (f4) begin
      meta4_q <= meta3_q;
      rsum_q  <= rsum_d;
    end
    if (ov_free && p4v_q) begin
      meta_out_q <= meta4_q;
      sum_out_q  <= vcs_pkg::CONV_W'(total_d);
    end
  end

  assign out_valid_o = ov_q;
  assign conv_sum_o  = sum_out_q;
  assign meta_o      = meta_out_q;

endmodule
